FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int CAPACITY    = 64;
   localparam int WEIGHT_BITS = 16;
   localparam int ADDR_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int SUM_BITS    = ADDR_BITS + 1;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [9:0]             node;
      logic [WEIGHT_BITS-1:0] weight;
      logic [9:0]             pred;
      logic [7:0]             line;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_POP_RD,
      ST_POP_TAKE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      logic     wr_new;
   } mem_ctl_type;

   typedef struct packed {
      logic      load;
      logic      pop_valid;
      logic      dropped;
      count_type count;
      logic      is_empty;
   } done_type;

   function automatic addr_type slot_addr(addr_type head, count_type offset);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(head) + SUM_BITS'(offset);
      if (sum >= SUM_BITS'(CAPACITY)) begin
         sum = sum - SUM_BITS'(CAPACITY);
      end
      return sum[ADDR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: design/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [9:0]  node_id;
   logic [15:0] weight;
   logic [9:0]  pred_id;
   logic [7:0]  line_id;

   modport source (output valid, cmd, node_id, weight, pred_id, line_id, input ready);
   modport sink   (input valid, cmd, node_id, weight, pred_id, line_id, output ready);
endinterface

interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic        pop_valid;
   logic [9:0]  out_node;
   logic [15:0] out_weight;
   logic [9:0]  out_pred;
   logic [7:0]  out_line;
   logic        dropped;
   logic [6:0]  entry_count;
   logic        is_empty;

   modport source (output valid, pop_valid, out_node, out_weight, out_pred, out_line,
                   dropped, entry_count, is_empty, input ready);
   modport sink   (input valid, pop_valid, out_node, out_weight, out_pred, out_line,
                   dropped, entry_count, is_empty, output ready);
endinterface

`default_nettype wire

FILE: design/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted-list min-priority queue held in a ring buffer memory.
// Insert: walking from the tail toward the head, each held entry whose weight
// is at or above the new weight moves one slot toward the tail, then the new
// entry is written into the freed slot. Pop reads and removes the head entry.
// Pop when empty and insert when full (dropped) go straight to the result.
// One item at a time; a new request is taken from the cycle after a result is
// staged; staging holds while the response register is occupied and not ready.
// Reset clears occupancy and head pointer; entry storage is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);
   import spq_pkg::*;

   entry_type   mem [CAPACITY];
   entry_type   rd_data_ff;
   entry_type   new_entry_ff;
   entry_type   wr_data;
   mem_ctl_type mem_ctl;
   done_type    done;
   logic        req_fire;
   logic        rsp_free;

   logic        rsp_valid_ff;
   logic        pop_valid_ff;
   logic [9:0]  out_node_ff;
   logic [15:0] out_weight_ff;
   logic [9:0]  out_pred_ff;
   logic [7:0]  out_line_ff;
   logic        dropped_ff;
   logic [6:0]  entry_count_ff;
   logic        is_empty_ff;

   assign req_fire = req.valid && req.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign wr_data  = mem_ctl.wr_new ? new_entry_ff : rd_data_ff;

   spq_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_cmd    (req.cmd),
      .new_weight (new_entry_ff.weight),
      .rd_weight  (rd_data_ff.weight),
      .rsp_free   (rsp_free),
      .req_ready  (req.ready),
      .mem_ctl    (mem_ctl),
      .done       (done)
   );

   always_ff @(posedge clock) begin
      if (req_fire) begin
         new_entry_ff.node   <= req.node_id;
         new_entry_ff.weight <= req.weight[WEIGHT_BITS-1:0];
         new_entry_ff.pred   <= req.pred_id;
         new_entry_ff.line   <= req.line_id;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[mem_ctl.wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[mem_ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done.load) begin
         pop_valid_ff   <= done.pop_valid;
         out_node_ff    <= done.pop_valid ? rd_data_ff.node : '0;
         out_weight_ff  <= done.pop_valid ? 16'(rd_data_ff.weight) : '0;
         out_pred_ff    <= done.pop_valid ? rd_data_ff.pred : '0;
         out_line_ff    <= done.pop_valid ? rd_data_ff.line : '0;
         dropped_ff     <= done.dropped;
         entry_count_ff <= 7'(done.count);
         is_empty_ff    <= done.is_empty;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pop_valid   = pop_valid_ff;
   assign rsp.out_node    = out_node_ff;
   assign rsp.out_weight  = out_weight_ff;
   assign rsp.out_pred    = out_pred_ff;
   assign rsp.out_line    = out_line_ff;
   assign rsp.dropped     = dropped_ff;
   assign rsp.entry_count = entry_count_ff;
   assign rsp.is_empty    = is_empty_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      done.load |-> rsp_free)
      else $error("result staged while response register is occupied");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req.ready)
      else $error("request taken while previous item still in progress");

   a_pop_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(pop_valid_ff && dropped_ff))
      else $error("result reports both a pop and a drop");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (is_empty_ff == (entry_count_ff == '0)))
      else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire

FILE: design/spq_seq.sv
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer: ring pointers, occupancy and the shared weight comparator that
// walks entries from the tail toward the head on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_seq (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_fire,
   input  wire logic                           req_cmd,
   input  wire logic [spq_pkg::WEIGHT_BITS-1:0] new_weight,
   input  wire logic [spq_pkg::WEIGHT_BITS-1:0] rd_weight,
   input  wire logic                           rsp_free,
   output logic                                req_ready,
   output spq_pkg::mem_ctl_type                mem_ctl,
   output spq_pkg::done_type                   done
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   addr_type  head_ff, head_in;
   count_type count_ff, count_in;
   count_type idx_ff, idx_in;
   logic      pop_ff, pop_in;
   logic      drop_ff, drop_in;
   logic      keep_moving;

   assign keep_moving = (rd_weight >= new_weight);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         pop_ff   <= 1'b0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pop_ff   <= pop_in;
         drop_ff  <= drop_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_INSERT) begin
                  if (count_ff == COUNT_BITS'(CAPACITY)) begin
                     state_in = ST_FINISH;
                  end else if (count_ff == '0) begin
                     state_in = ST_INS_PUT;
                  end else begin
                     state_in = ST_INS_RD;
                  end
               end else begin
                  state_in = (count_ff == '0) ? ST_FINISH : ST_POP_RD;
               end
            end
         end
         ST_INS_RD:   state_in = ST_INS_CMP;
         ST_INS_CMP: begin
            if (!keep_moving) begin
               state_in = ST_FINISH;
            end else if (idx_ff == COUNT_BITS'(1)) begin
               state_in = ST_INS_PUT;
            end else begin
               state_in = ST_INS_RD;
            end
         end
         ST_INS_PUT:  state_in = ST_FINISH;
         ST_POP_RD:   state_in = ST_POP_TAKE;
         ST_POP_TAKE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      pop_in   = pop_ff;
      drop_in  = drop_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pop_in  = 1'b0;
               drop_in = (req_cmd == CMD_INSERT) && (count_ff == COUNT_BITS'(CAPACITY));
               idx_in  = count_ff;
            end
         end
         ST_INS_CMP: begin
            if (keep_moving) begin
               idx_in = idx_ff - COUNT_BITS'(1);
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         ST_INS_PUT: count_in = count_ff + COUNT_BITS'(1);
         ST_POP_TAKE: begin
            head_in  = slot_addr(head_ff, COUNT_BITS'(1));
            count_in = count_ff - COUNT_BITS'(1);
            pop_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      mem_ctl.rd_en   = 1'b0;
      mem_ctl.rd_addr = slot_addr(head_ff, idx_ff - COUNT_BITS'(1));
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_addr = slot_addr(head_ff, idx_ff);
      mem_ctl.wr_new  = 1'b1;
      done.load       = 1'b0;
      done.pop_valid  = pop_ff;
      done.dropped    = drop_ff;
      done.count      = count_ff;
      done.is_empty   = (count_ff == '0);
      case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_INS_RD:  mem_ctl.rd_en = 1'b1;
         ST_INS_CMP: begin
            mem_ctl.wr_en  = 1'b1;
            mem_ctl.wr_new = !keep_moving;
         end
         ST_INS_PUT: mem_ctl.wr_en = 1'b1;
         ST_POP_RD: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = head_ff;
         end
         ST_FINISH:  done.load = rsp_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire
